[rtl/core/array_bst_insert_and_inorder_unit_assert.svh]
// assertion macros for the array bst insert and inorder unit
`ifndef ARRAY_BST_INSERT_AND_INORDER_UNIT_ASSERT_SVH
`define ARRAY_BST_INSERT_AND_INORDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ABST_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abst assertion failed");
`define ABST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abst assertion failed");
`else
`define ABST_ASSERT_IMPLY(label, ante, cons)
`define ABST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/core/abst_pkg.sv]
// shared types, codes and microcode rom of the array bst unit
package abst_pkg;

    localparam int KEY_W = 16;
    localparam int UPC_W = 4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    localparam logic [2:0] STS_INSERTED  = 3'd0;
    localparam logic [2:0] STS_TOO_DEEP  = 3'd1;
    localparam logic [2:0] STS_DUPLICATE = 3'd2;
    localparam logic [2:0] STS_LISTED    = 3'd3;
    localparam logic [2:0] STS_EMPTY     = 3'd4;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key;
    } cmd_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [KEY_W-1:0] out_key;
        logic             last;
    } rsp_t;

    // jump conditions
    localparam logic [2:0] C_ALWAYS     = 3'd0;
    localparam logic [2:0] C_NOT_USED   = 3'd1;
    localparam logic [2:0] C_USED       = 3'd2;
    localparam logic [2:0] C_KEY_EQ     = 3'd3;
    localparam logic [2:0] C_LEVEL_LAST = 3'd4;
    localparam logic [2:0] C_SP_ZERO    = 3'd5;
    localparam logic [2:0] C_NO_PEND    = 3'd6;

    // node pointer operations
    localparam logic [2:0] IX_HOLD    = 3'd0;
    localparam logic [2:0] IX_DESCEND = 3'd1;
    localparam logic [2:0] IX_PUSH    = 3'd2;
    localparam logic [2:0] IX_POP     = 3'd3;
    localparam logic [2:0] IX_RIGHT   = 3'd4;

    // result word sources
    localparam logic [2:0] OUT_NONE      = 3'd0;
    localparam logic [2:0] OUT_HANDLED   = 3'd1;
    localparam logic [2:0] OUT_PEND_MID  = 3'd2;
    localparam logic [2:0] OUT_PEND_LAST = 3'd3;
    localparam logic [2:0] OUT_EMPTY     = 3'd4;

    // program steps
    localparam logic [UPC_W-1:0] U_WALK   = 4'd0;
    localparam logic [UPC_W-1:0] U_CMP    = 4'd1;
    localparam logic [UPC_W-1:0] U_DEPTH  = 4'd2;
    localparam logic [UPC_W-1:0] U_DESC   = 4'd3;
    localparam logic [UPC_W-1:0] U_INS    = 4'd4;
    localparam logic [UPC_W-1:0] U_DUP    = 4'd5;
    localparam logic [UPC_W-1:0] U_DEEP   = 4'd6;
    localparam logic [UPC_W-1:0] U_DOWN   = 4'd7;
    localparam logic [UPC_W-1:0] U_CHECK  = 4'd8;
    localparam logic [UPC_W-1:0] U_POP    = 4'd9;
    localparam logic [UPC_W-1:0] U_LIST   = 4'd10;
    localparam logic [UPC_W-1:0] U_FIN    = 4'd11;
    localparam logic [UPC_W-1:0] U_LAST   = 4'd12;
    localparam logic [UPC_W-1:0] U_EMPTY  = 4'd13;

    typedef struct packed {
        logic [2:0]       cond;
        logic [UPC_W-1:0] target;
        logic [2:0]       idx_op;
        logic             wr;
        logic [2:0]       out_op;
        logic [2:0]       status;
        logic             load_pend;
        logic             done;
    } uword_t;

    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] step);
        uword_t w;
        w = '0;
        w.cond   = C_ALWAYS;
        w.target = step;
        w.idx_op = IX_HOLD;
        w.out_op = OUT_NONE;
        w.status = STS_INSERTED;
        case (step)
            U_WALK:
            begin
                w.cond   = C_NOT_USED;
                w.target = U_INS;
            end
            U_CMP:
            begin
                w.cond   = C_KEY_EQ;
                w.target = U_DUP;
            end
            U_DEPTH:
            begin
                w.cond   = C_LEVEL_LAST;
                w.target = U_DEEP;
            end
            U_DESC:
            begin
                w.idx_op = IX_DESCEND;
                w.target = U_WALK;
            end
            U_INS:
            begin
                w.wr     = 1'b1;
                w.out_op = OUT_HANDLED;
                w.status = STS_INSERTED;
                w.done   = 1'b1;
            end
            U_DUP:
            begin
                w.out_op = OUT_HANDLED;
                w.status = STS_DUPLICATE;
                w.done   = 1'b1;
            end
            U_DEEP:
            begin
                w.out_op = OUT_HANDLED;
                w.status = STS_TOO_DEEP;
                w.done   = 1'b1;
            end
            U_DOWN:
            begin
                w.cond   = C_USED;
                w.idx_op = IX_PUSH;
                w.target = U_DOWN;
            end
            U_CHECK:
            begin
                w.cond   = C_SP_ZERO;
                w.target = U_FIN;
            end
            U_POP:
            begin
                w.idx_op = IX_POP;
                w.target = U_LIST;
            end
            U_LIST:
            begin
                w.idx_op    = IX_RIGHT;
                w.out_op    = OUT_PEND_MID;
                w.load_pend = 1'b1;
                w.target    = U_DOWN;
            end
            U_FIN:
            begin
                w.cond   = C_NO_PEND;
                w.target = U_EMPTY;
            end
            U_LAST:
            begin
                w.out_op = OUT_PEND_LAST;
                w.done   = 1'b1;
            end
            U_EMPTY:
            begin
                w.out_op = OUT_EMPTY;
                w.done   = 1'b1;
            end
            default:
            begin
                w.done = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

[rtl/core/abst_ram.sv]
// generic simple dual port ram with registered read
module abst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/array_bst_insert_and_inorder_unit.sv]
// array bst unit: microcoded insert and inorder dump over a heap-indexed node store
//
//   channel   valid      stall      word    direction
//   command   cmd_valid  cmd_stall  cmd     into the unit
//   response  rsp_valid  rsp_stall  rsp     out of the unit
//
// after reset every entry of the occupied store is cleared, with cmd_stall high
// one command at a time; the node store ram read is one node per cycle
// insert: at each occupied node walked, checks for an equal key and the last level, then descends
// dump: pushes down the left spine, pops a node, sends the held key and holds this one, goes right
// rsp_stall holds the sequencer only at a step that emits a word while one is waiting
`include "array_bst_insert_and_inorder_unit_assert.svh"

module array_bst_insert_and_inorder_unit
    import abst_pkg::*;
#(
    parameter int LEVELS   = 6,
    parameter int KEY_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int SK     = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int DEPTH  = 1 << LEVELS;
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int STK_AW = $clog2(LEVELS);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [LEVELS-1:0] clr_reg, clr_next;
    logic [UPC_W-1:0]  upc_reg, upc_next;
    logic              op_reg, op_next;
    logic [SK-1:0]     key_reg, key_next;
    logic [LEVELS:0]   idx_reg, idx_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [LVL_W-1:0]  sp_reg, sp_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SK-1:0]     pend_key_reg, pend_key_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;
    logic [LEVELS-1:0] stack_reg [LEVELS];

    uword_t            uw;
    logic              accept;
    logic              clearing;
    logic              running;
    logic              occ_rd;
    logic [SK-1:0]     key_rd;
    logic              used;
    logic              key_eq;
    logic              key_gt;
    logic              cond_true;
    logic              taken;
    logic              emit_req;
    logic              go;
    logic              fire;
    logic              emit_fire;
    logic              wr_fire;
    logic [LVL_W-1:0]  sp_dec;
    logic [LEVELS-1:0] occ_waddr;

    assign uw        = ucode_rom(upc_reg);
    assign clearing  = (state_reg == S_CLEAR);
    assign running   = (state_reg == S_RUN);
    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;

    assign used   = occ_rd && !idx_reg[LEVELS];
    assign key_eq = (key_reg == key_rd);
    assign key_gt = (key_reg > key_rd);
    assign sp_dec = sp_reg - LVL_W'(1);

    always_comb
    begin
        case (uw.cond)
            C_ALWAYS:     cond_true = 1'b1;
            C_NOT_USED:   cond_true = !used;
            C_USED:       cond_true = used;
            C_KEY_EQ:     cond_true = key_eq;
            C_LEVEL_LAST: cond_true = (level_reg == LVL_W'(LEVELS));
            C_SP_ZERO:    cond_true = (sp_reg == '0);
            C_NO_PEND:    cond_true = !pend_valid_reg;
            default:      cond_true = 1'b0;
        endcase
    end

    assign taken = running && cond_true;

    always_comb
    begin
        case (uw.out_op)
            OUT_HANDLED:   emit_req = taken;
            OUT_PEND_MID:  emit_req = taken && pend_valid_reg;
            OUT_PEND_LAST: emit_req = taken;
            OUT_EMPTY:     emit_req = taken;
            default:       emit_req = 1'b0;
        endcase
    end

    assign go        = !(emit_req && rsp_valid_reg && rsp_stall);
    assign fire      = taken && go;
    assign emit_fire = emit_req && go;
    assign wr_fire   = fire && uw.wr;

    // sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        upc_next        = upc_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        level_next      = level_reg;
        sp_next         = sp_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + LEVELS'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next      = S_RUN;
                    op_next         = cmd.opcode;
                    key_next        = cmd.key[SK-1:0];
                    upc_next        = (cmd.opcode == OP_DUMP) ? U_DOWN : U_WALK;
                    idx_next        = (LEVELS + 1)'(1);
                    level_next      = LVL_W'(1);
                    sp_next         = '0;
                    pend_valid_next = 1'b0;
                end
            end
            S_RUN:
            begin
                if (!cond_true)
                begin
                    upc_next = upc_reg + UPC_W'(1);
                end
                else if (go)
                begin
                    upc_next = uw.target;
                    if (uw.done)
                    begin
                        state_next = S_IDLE;
                    end
                    case (uw.idx_op)
                        IX_DESCEND:
                        begin
                            idx_next   = {idx_reg[LEVELS-1:0], key_gt};
                            level_next = level_reg + LVL_W'(1);
                        end
                        IX_PUSH:
                        begin
                            idx_next = {idx_reg[LEVELS-1:0], 1'b0};
                            sp_next  = sp_reg + LVL_W'(1);
                        end
                        IX_POP:
                        begin
                            idx_next = {1'b0, stack_reg[sp_dec[STK_AW-1:0]]};
                            sp_next  = sp_dec;
                        end
                        IX_RIGHT:
                        begin
                            idx_next = {idx_reg[LEVELS-1:0], 1'b1};
                        end
                        default:
                        begin
                            idx_next = idx_reg;
                        end
                    endcase
                    if (uw.load_pend)
                    begin
                        pend_valid_next = 1'b1;
                        pend_key_next   = key_rd;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response register
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (emit_fire)
        begin
            rsp_valid_next = 1'b1;
            case (uw.out_op)
                OUT_HANDLED:
                begin
                    rsp_next.status  = uw.status;
                    rsp_next.out_key = KEY_W'(key_reg);
                    rsp_next.last    = 1'b1;
                end
                OUT_PEND_MID:
                begin
                    rsp_next.status  = STS_LISTED;
                    rsp_next.out_key = KEY_W'(pend_key_reg);
                    rsp_next.last    = 1'b0;
                end
                OUT_PEND_LAST:
                begin
                    rsp_next.status  = STS_LISTED;
                    rsp_next.out_key = KEY_W'(pend_key_reg);
                    rsp_next.last    = 1'b1;
                end
                default:
                begin
                    rsp_next.status  = STS_EMPTY;
                    rsp_next.out_key = '0;
                    rsp_next.last    = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            upc_reg        <= U_WALK;
            idx_reg        <= '0;
            level_reg      <= '0;
            sp_reg         <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            upc_reg        <= upc_next;
            idx_reg        <= idx_next;
            level_reg      <= level_next;
            sp_reg         <= sp_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        pend_key_reg <= pend_key_next;
        rsp_reg      <= rsp_next;
        if (fire && (uw.idx_op == IX_PUSH))
        begin
            stack_reg[sp_reg[STK_AW-1:0]] <= idx_reg[LEVELS-1:0];
        end
    end

    assign occ_waddr = clearing ? clr_reg : idx_reg[LEVELS-1:0];

    abst_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_occ_ram (
        .clk   (clk),
        .we    (clearing || wr_fire),
        .waddr (occ_waddr),
        .wdata (!clearing),
        .raddr (idx_next[LEVELS-1:0]),
        .rdata (occ_rd)
    );

    abst_ram #(
        .WIDTH (SK),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (wr_fire),
        .waddr (idx_reg[LEVELS-1:0]),
        .wdata (key_reg),
        .raddr (idx_next[LEVELS-1:0]),
        .rdata (key_rd)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ABST_ASSERT_IMPLY(a_sp_bound, running, sp_reg <= LVL_W'(LEVELS))
    `ABST_ASSERT_IMPLY(a_pend_dump_only, pend_valid_reg, op_reg == OP_DUMP)
    `ABST_ASSERT_IMPLY(a_wr_free_node, wr_fire, !idx_reg[LEVELS] && !occ_rd)
    `ABST_ASSERT_IMPLY(a_no_overwrite, emit_fire, !(rsp_valid_reg && rsp_stall))
    `ABST_ASSERT_NEXT(a_emit_shown, emit_fire, rsp_valid_reg)

endmodule

[tb/testbench.sv]
// self-checking testbench for the array bst insert and inorder unit
module testbench
    import abst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 6;
    localparam int NODE_MAX   = (1 << DEPTH) - 1;
    localparam int RAND_ITEMS = 500;
    localparam int IDLE_PCT   = 32;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN      = 300;
    localparam int LIMIT      = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    cmd_t cmd_pending[$];
    rsp_t rsp_due[$];
    rsp_t due_w;
    logic [KEY_W-1:0] seen_keys[$];

    logic [KEY_W-1:0] tree_key[0:2*NODE_MAX+1];
    bit tree_used[0:2*NODE_MAX+1];

    int cycle = 0;
    int n_taken = 0;
    int bad_words = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit calm;

    array_bst_insert_and_inorder_unit #(
        .LEVELS   (DEPTH),
        .KEY_BITS (KEY_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    assign calm = (n_taken >= 200) && (n_taken < 300);

    function automatic logic [2:0] tree_insert(input logic [KEY_W-1:0] k);
        int idx;
        int lvl;
        int child;
        logic [2:0] st;
        bit busy;
        idx = 1;
        lvl = 1;
        busy = 1'b1;
        st = STS_INSERTED;
        if (!tree_used[1])
        begin
            tree_key[1] = k;
            tree_used[1] = 1'b1;
            busy = 1'b0;
        end
        while (busy)
        begin
            if (k == tree_key[idx])
            begin
                st = STS_DUPLICATE;
                busy = 1'b0;
            end
            else if (lvl >= DEPTH)
            begin
                st = STS_TOO_DEEP;
                busy = 1'b0;
            end
            else
            begin
                child = (k > tree_key[idx]) ? 2 * idx + 1 : 2 * idx;
                if (!tree_used[child])
                begin
                    tree_key[child] = k;
                    tree_used[child] = 1'b1;
                    busy = 1'b0;
                end
                else
                begin
                    idx = child;
                    lvl++;
                end
            end
        end
        return st;
    endfunction

    function automatic void tree_inorder();
        int path[$];
        int cur;
        int cnt;
        rsp_t held;
        cur = 1;
        cnt = 0;
        held = '0;
        while (path.size() > 0 || tree_used[cur])
        begin
            while (tree_used[cur])
            begin
                path.push_back(cur);
                cur = 2 * cur;
            end
            cur = path.pop_back();
            if (cnt > 0)
                rsp_due.push_back(held);
            held = '{status: STS_LISTED, out_key: tree_key[cur], last: 1'b0};
            cnt++;
            cur = 2 * cur + 1;
        end
        if (cnt == 0)
            held = '{status: STS_EMPTY, out_key: '0, last: 1'b0};
        held.last = 1'b1;
        rsp_due.push_back(held);
    endfunction

    function automatic void predict_word(input cmd_t c);
        if (c.opcode == OP_INSERT)
            rsp_due.push_back('{status: tree_insert(c.key), out_key: c.key, last: 1'b1});
        else
            tree_inorder();
    endfunction

    task automatic add_cmd(input logic op, input logic [KEY_W-1:0] k);
        cmd_pending.push_back('{opcode: op, key: k});
        if (op == OP_INSERT)
            seen_keys.push_back(k);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            if (cmd_valid)
            begin
                predict_word(cmd);
                n_taken <= n_taken + 1;
            end
            if (cmd_pending.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                cmd_valid <= 1'b1;
                cmd <= cmd_pending.pop_front();
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // response stall; one long hold-off on a word after 60 commands
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (!hold_done && n_taken >= 60 && rsp_valid)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected word: status %0d key %h last %0d",
                             rsp.status, rsp.out_key, rsp.last);
            end
            else
            begin
                due_w = rsp_due.pop_front();
                if (rsp.status !== due_w.status || rsp.out_key !== due_w.out_key ||
                    rsp.last !== due_w.last)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("word mismatch: expected %0d %h %0d, got %0d %h %0d",
                                 due_w.status, due_w.out_key, due_w.last,
                                 rsp.status, rsp.out_key, rsp.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int pick;
        // empty tree, root, duplicate at root, key extremes
        add_cmd(OP_DUMP, 16'h1234);
        add_cmd(OP_INSERT, 16'h8000);
        add_cmd(OP_INSERT, 16'h8000);
        add_cmd(OP_INSERT, 16'h0000);
        add_cmd(OP_INSERT, 16'hFFFF);
        add_cmd(OP_DUMP, 16'hFFFF);
        // a chain to the last level, then one below it
        add_cmd(OP_INSERT, 16'hC000);
        add_cmd(OP_INSERT, 16'hE000);
        add_cmd(OP_INSERT, 16'hF000);
        add_cmd(OP_INSERT, 16'hF800);
        add_cmd(OP_INSERT, 16'hFC00);
        add_cmd(OP_INSERT, 16'hF800);
        add_cmd(OP_INSERT, 16'h0000);
        add_cmd(OP_INSERT, 16'hFFFF);
        add_cmd(OP_INSERT, 16'h4000);
        add_cmd(OP_DUMP, 16'h0000);
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                add_cmd(OP_DUMP, 16'($urandom));
            else if (pick < 35)
                add_cmd(OP_INSERT, seen_keys[$urandom_range(seen_keys.size() - 1)]);
            else
                add_cmd(OP_INSERT, 16'($urandom));
        end
        add_cmd(OP_DUMP, 16'h0000);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_pending.size() > 0 || cmd_valid)
            @(posedge clk);
        while (rsp_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (bad_words == 0 && rsp_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
